// ----- src/ttgc_pkg.sv -----
// Shared types and constants of the touch tap gesture classifier.
package ttgc_pkg;

    localparam int PAD_COUNT      = 10;
    localparam int DURATION_BITS  = 16;
    localparam int LIMIT_BITS     = 16;
    localparam int WINDOW_BITS    = 10;
    localparam int PAD_SEL_BITS   = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int S_TDATA_BITS   = ((PAD_COUNT + 7) / 8) * 8;
    localparam int M_TDATA_BITS   = 8;

    typedef enum logic [2:0] {
        GEST_SINGLE   = 3'd0,
        GEST_LONG     = 3'd1,
        GEST_HOLD     = 3'd2,
        GEST_SHUTDOWN = 3'd3,
        GEST_DOUBLE   = 3'd4
    } t_gesture;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_TOUCH = 1'b1
    } t_opcode;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_SELECT     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_LIMIT     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHUTDOWN_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TICKS   = 3'd4;

    typedef struct packed {
        logic [PAD_SEL_BITS-1:0] pad_select;
        logic [LIMIT_BITS-1:0]   long_limit;
        logic [LIMIT_BITS-1:0]   hold_limit;
        logic [LIMIT_BITS-1:0]   shutdown_limit;
        logic [WINDOW_BITS-1:0]  window_ticks;
    } t_cfg;

    typedef struct packed {
        logic     gesture_valid;
        t_gesture gesture;
        logic     trigger_above;
    } t_result;

endpackage

// ----- src/ttgc_core.sv -----
// Gesture state machine: press timing, decision window and classification.
module ttgc_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  ttgc_pkg::t_opcode               i_opcode,
    input  logic [ttgc_pkg::PAD_COUNT-1:0]  i_mask,
    input  ttgc_pkg::t_cfg                  i_cfg,
    output ttgc_pkg::t_result               o_result
);
    import ttgc_pkg::*;

    logic                     r_pressed, n_pressed;
    logic                     r_deciding, n_deciding;
    logic                     r_second_press, n_second_press;
    logic [DURATION_BITS-1:0] r_press_timer, n_press_timer;
    logic [DURATION_BITS-1:0] r_held_duration, n_held_duration;
    logic [WINDOW_BITS-1:0]   r_window_timer, n_window_timer;

    logic [PAD_COUNT-1:0]     w_shifted;
    logic                     w_hit;
    logic [WINDOW_BITS:0]     w_window_next;
    t_gesture                 w_class;

    assign w_shifted     = i_mask >> i_cfg.pad_select;
    assign w_hit         = (32'(i_cfg.pad_select) < 32'(PAD_COUNT)) && w_shifted[0];
    assign w_window_next = {1'b0, r_window_timer} + {{WINDOW_BITS{1'b0}}, 1'b1};

    always_comb begin
        priority if (r_second_press) begin
            w_class = GEST_DOUBLE;
        end else if (32'(r_held_duration) > 32'(i_cfg.shutdown_limit)) begin
            w_class = GEST_SHUTDOWN;
        end else if (32'(r_held_duration) > 32'(i_cfg.hold_limit)) begin
            w_class = GEST_HOLD;
        end else if (32'(r_held_duration) > 32'(i_cfg.long_limit)) begin
            w_class = GEST_LONG;
        end else begin
            w_class = GEST_SINGLE;
        end
    end

    always_comb begin
        n_pressed       = r_pressed;
        n_deciding      = r_deciding;
        n_second_press  = r_second_press;
        n_press_timer   = r_press_timer;
        n_held_duration = r_held_duration;
        n_window_timer  = r_window_timer;
        o_result.gesture_valid = 1'b0;
        o_result.gesture       = GEST_SINGLE;
        unique case (i_opcode)
            OP_TOUCH: begin
                if (w_hit) begin
                    n_pressed = !r_pressed;
                    if (!r_pressed) begin
                        // press inside an open window marks double tap
                        if (r_deciding) begin
                            n_second_press = 1'b1;
                        end
                        n_press_timer = '0;
                    end else if (!r_deciding) begin
                        n_held_duration = r_press_timer;
                        n_deciding      = 1'b1;
                        n_second_press  = 1'b0;
                        n_window_timer  = '0;
                    end
                end
            end
            OP_TICK: begin
                if (r_pressed && (r_press_timer != {DURATION_BITS{1'b1}})) begin
                    n_press_timer = r_press_timer + DURATION_BITS'(1);
                end
                if (r_deciding) begin
                    if (w_window_next >= {1'b0, i_cfg.window_ticks}) begin
                        o_result.gesture_valid = 1'b1;
                        o_result.gesture       = w_class;
                        n_deciding             = 1'b0;
                        n_second_press         = 1'b0;
                        n_window_timer         = '0;
                    end else begin
                        n_window_timer = w_window_next[WINDOW_BITS-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.trigger_above = n_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed       <= 1'b0;
            r_deciding      <= 1'b0;
            r_second_press  <= 1'b0;
            r_press_timer   <= '0;
            r_held_duration <= '0;
            r_window_timer  <= '0;
        end else if (i_step) begin
            r_pressed       <= n_pressed;
            r_deciding      <= n_deciding;
            r_second_press  <= n_second_press;
            r_press_timer   <= n_press_timer;
            r_held_duration <= n_held_duration;
            r_window_timer  <= n_window_timer;
        end
    end

    a_second_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second_press |-> r_deciding)
        else $error("double tap mark without an open window");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pressed) && $stable(r_deciding) && $stable(r_window_timer))
        else $error("state moved without a step");

    a_decision_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.gesture_valid |-> (i_opcode == OP_TICK) && r_deciding)
        else $error("gesture decided outside a window tick");

endmodule

// ----- src/touch_tap_gesture_classifier_unit.sv -----
// Top level of the touch tap gesture classifier: channels, config and pipeline.
//
// Usage:
//   Input stream (s_axis_*): one request per tick or touch interrupt.
//   tuser carries the opcode (0 tick, 1 interrupt); tdata carries the pad
//   status mask in its low bits. Every request yields exactly one result on
//   the output stream (m_axis_*): gesture_valid, gesture code and the
//   current trigger direction.
//   Configuration channel (i_cfg_*): register index and data, taken at any
//   edge where i_cfg_valid is high (o_cfg_ready is always high). Write only
//   while no request is in flight.
//   An accepted request waits in the input register and moves into the result
//   register, raising m_axis_tvalid, once that register is empty or being read.
//   Throughput: one request per cycle while the receiver does not stall; the
//   state update between the input and result registers is combinational.
//   Reset (synchronous, active low) clears both registers, the gesture
//   state and loads the default limits.
//   A stalled receiver holds the result; one more request is taken into the
//   input register, after which s_axis_tready drops until the result leaves.
module touch_tap_gesture_classifier_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [PAD_COUNT-1:0] status_mask, zero padded
    input  logic [ttgc_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
    // [0] opcode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] gesture_valid, [3:1] gesture, [4] trigger_above, zero padded
    output logic [ttgc_pkg::M_TDATA_BITS-1:0]   m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ttgc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ttgc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ttgc_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_in_valid;
    t_opcode              r_in_opcode;
    logic [PAD_COUNT-1:0] r_in_mask;
    logic                 r_out_valid;
    t_result              r_out;
    t_result              w_result;
    logic                 w_advance;

    assign o_cfg_ready   = 1'b1;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_BITS - 5){1'b0}},
                            r_out.trigger_above, r_out.gesture, r_out.gesture_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pad_select     <= '0;
            r_cfg.long_limit     <= LIMIT_BITS'(500);
            r_cfg.hold_limit     <= LIMIT_BITS'(1500);
            r_cfg.shutdown_limit <= LIMIT_BITS'(5000);
            r_cfg.window_ticks   <= WINDOW_BITS'(150);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAD_SELECT:     r_cfg.pad_select     <= i_cfg_data[PAD_SEL_BITS-1:0];
                REG_LONG_LIMIT:     r_cfg.long_limit     <= i_cfg_data[LIMIT_BITS-1:0];
                REG_HOLD_LIMIT:     r_cfg.hold_limit     <= i_cfg_data[LIMIT_BITS-1:0];
                REG_SHUTDOWN_LIMIT: r_cfg.shutdown_limit <= i_cfg_data[LIMIT_BITS-1:0];
                REG_WINDOW_TICKS:   r_cfg.window_ticks   <= i_cfg_data[WINDOW_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_opcode <= t_opcode'(s_axis_tuser);
            r_in_mask   <= s_axis_tdata[PAD_COUNT-1:0];
        end
    end

    ttgc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_opcode (r_in_opcode),
        .i_mask   (r_in_mask),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

endmodule
